// File: hdl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared constants and controller/datapath handshake types for the sliding
// mean/median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int CSR_W          = 5;
   localparam int DEF_MAX_WINDOW = 16;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(3);

   typedef struct packed {
      logic accept;
      logic fetch;
      logic calc_start;
      logic calc_step;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic hit;
      logic fetch_last;
      logic calc_done;
      logic out_free;
   } ctl_status_type;

endpackage

`default_nettype wire

// File: hdl/smm_req_if.sv
// ----------------------------------------------------------------------------
// smm_req_if
// Sample channel: valid/ready handshake carrying one sample word.
// ----------------------------------------------------------------------------
`default_nettype none

interface smm_req_if import smm_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);

endinterface

`default_nettype wire

// File: hdl/smm_rsp_if.sv
// ----------------------------------------------------------------------------
// smm_rsp_if
// Result channel: valid/ready handshake carrying one mean/median/blend word.
// ----------------------------------------------------------------------------
`default_nettype none

interface smm_rsp_if import smm_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mean_value;
   logic signed [SAMPLE_W-1:0] median_value;
   logic signed [SAMPLE_W-1:0] blend_value;

   modport source (output valid, output mean_value, output median_value,
                   output blend_value, input ready);
   modport sink   (input valid, input mean_value, input median_value,
                   input blend_value, output ready);

endinterface

`default_nettype wire

// File: hdl/sliding_mean_median_filter_core.sv
// ----------------------------------------------------------------------------
// sliding_mean_median_filter_core
// Sliding-window mean, median and blended average over signed 16-bit samples.
//
//   channel   direction  word                                   handshake
//   req_chan  in         sample, last_sample                    valid/ready
//   rsp_chan  out        mean_value, median_value, blend_value  valid/ready
//   csr_*     in         window_size (5 bits)                   write enable
//
// A word that completes a window of w samples has its window fetched from the
// single-port ring memory into the sorter row, and then runs the bit-serial
// divider for NW = 16 + clog2(MAX_WINDOW) steps. A word that gives no result
// goes from the check state straight back to idle.
// Synchronous reset clears the sequence and sets window_size to 3. A stalled
// result sits in the output register while the next word is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_mean_median_filter_core import smm_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  wire logic             clock,
   input  wire logic             reset,
   smm_req_if.sink               req_chan,
   smm_rsp_if.source             rsp_chan,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   smm_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   smm_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_sample       (req_chan.sample),
      .req_last_sample  (req_chan.last_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_mean_value   (rsp_chan.mean_value),
      .rsp_median_value (rsp_chan.median_value),
      .rsp_blend_value  (rsp_chan.blend_value)
   );

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded into a full output register");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_chan.ready)
      else $error("sample port ready right after accepting a word");

   a_calc_needs_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.calc_start |-> status.hit)
      else $error("calculation started without a full window");

endmodule

`default_nettype wire

// File: hdl/smm_ctl.sv
// ----------------------------------------------------------------------------
// smm_ctl
// Sequencer: accepts a sample word and, if its window is full, runs the window
// fetch/sort, then divide and median select, and loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ctl import smm_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire ctl_status_type status,
   output ctl_cmd_type         cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      FETCH,
      DRAIN,
      START,
      CALC,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.accept = 1'b1;
               state_in   = CHECK;
            end
         end
         CHECK: begin
            state_in = status.hit ? FETCH : IDLE;
         end
         FETCH: begin
            cmd.fetch = 1'b1;
            if (status.fetch_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = START;
         end
         START: begin
            cmd.calc_start = 1'b1;
            state_in       = CALC;
         end
         CALC: begin
            cmd.calc_step = 1'b1;
            if (status.calc_done) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

// File: hdl/smm_dp.sv
// ----------------------------------------------------------------------------
// smm_dp
// Datapath: sample ring memory, insertion sorter row, window accumulator,
// restoring divider, blend adder and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_dp import smm_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_W-1:0]           csr_wr_data,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_last_sample,
   input  wire ctl_cmd_type                cmd,
   output ctl_status_type                  status,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic signed [SAMPLE_W-1:0]      rsp_mean_value,
   output logic signed [SAMPLE_W-1:0]      rsp_median_value,
   output logic signed [SAMPLE_W-1:0]      rsp_blend_value
);

   localparam int AW  = $clog2(MAX_WINDOW);
   localparam int WW  = $clog2(MAX_WINDOW + 1);
   localparam int TW  = AW + 2;
   localparam int NW  = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int SW  = NW + 1;
   localparam int DCW = $clog2(NW + 1);

   logic [CSR_W-1:0]           csr_ff;
   logic [WW-1:0]              weff;
   logic [WW-1:0]              w_ff;
   logic [AW-1:0]              wp_ff;
   logic [WW-1:0]              fill_ff;
   logic [WW-1:0]              fill_in;
   logic                       hit_ff;
   logic [TW-1:0]              base_sum;
   logic [AW-1:0]              base_in;

   logic signed [SAMPLE_W-1:0] window_store_ff [MAX_WINDOW];
   logic [AW-1:0]              rd_addr_ff;
   logic [WW-1:0]              rd_cnt_ff;
   logic                       rd_vld_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   logic signed [SW-1:0]       sum_ff;
   logic [SW-1:0]              abs_sum;

   logic signed [SAMPLE_W-1:0] cell_ff [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] cell_in [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]      vld_ff;
   logic [MAX_WINDOW-1:0]      gt;
   logic [WW-1:0]              shift_cnt_ff;
   logic [WW-1:0]              half_w;
   logic                       shift_en;

   logic [WW-1:0]              rem_ff;
   logic [NW-1:0]              quo_ff;
   logic                       neg_ff;
   logic [DCW-1:0]             div_cnt_ff;
   logic [WW:0]                rem_shift;
   logic                       rem_ge;
   logic                       div_en;

   logic signed [SAMPLE_W-1:0] mean_in;
   logic signed [SAMPLE_W:0]   blend_sum;
   logic signed [SAMPLE_W:0]   blend_adj;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] mean_ff;
   logic signed [SAMPLE_W-1:0] median_ff;
   logic signed [SAMPLE_W-1:0] blend_ff;

   always_comb begin
      if (csr_ff == '0) begin
         weff = WW'(1);
      end else if (int'(csr_ff) > MAX_WINDOW) begin
         weff = WW'(MAX_WINDOW);
      end else begin
         weff = WW'(csr_ff);
      end
   end

   assign fill_in  = (fill_ff == WW'(MAX_WINDOW)) ? fill_ff : fill_ff + WW'(1);
   assign base_sum = TW'(wp_ff) + TW'(1) + TW'(MAX_WINDOW) - TW'(weff);
   assign base_in  = (base_sum >= TW'(MAX_WINDOW)) ? AW'(base_sum - TW'(MAX_WINDOW))
                                                   : AW'(base_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff  <= CSR_RESET;
         wp_ff   <= '0;
         fill_ff <= '0;
         hit_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            hit_ff <= (fill_in >= weff);
            if (req_last_sample) begin
               wp_ff   <= '0;
               fill_ff <= '0;
            end else begin
               wp_ff   <= (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + AW'(1);
               fill_ff <= fill_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         window_store_ff[wp_ff] <= req_sample;
      end
      if (cmd.fetch) begin
         rd_data_ff <= window_store_ff[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         rd_cnt_ff <= '0;
      end else begin
         rd_vld_ff <= cmd.fetch;
         if (cmd.accept) begin
            rd_cnt_ff <= '0;
         end else if (cmd.fetch) begin
            rd_cnt_ff <= rd_cnt_ff + WW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         w_ff       <= weff;
         rd_addr_ff <= base_in;
         sum_ff     <= '0;
      end else begin
         if (cmd.fetch) begin
            rd_addr_ff <= (rd_addr_ff == AW'(MAX_WINDOW - 1)) ? '0 : rd_addr_ff + AW'(1);
         end
         if (rd_vld_ff) begin
            sum_ff <= sum_ff + SW'(rd_data_ff);
         end
      end
   end

   // sorter row: cells stay ascending, empty cells act as +infinity
   assign half_w   = w_ff >> 1;
   assign shift_en = cmd.calc_step && (shift_cnt_ff != half_w);

   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      assign gt[g] = !vld_ff[g] || (cell_ff[g] > rd_data_ff);

      always_comb begin
         cell_in[g] = cell_ff[g];
         if (rd_vld_ff) begin
            if (g == 0) begin
               if (gt[g]) begin
                  cell_in[g] = rd_data_ff;
               end
            end else if (gt[g]) begin
               cell_in[g] = gt[(g > 0) ? g - 1 : g] ? cell_ff[(g > 0) ? g - 1 : g]
                                                    : rd_data_ff;
            end
         end else if (shift_en) begin
            if (g < MAX_WINDOW - 1) begin
               cell_in[g] = cell_ff[(g < MAX_WINDOW - 1) ? g + 1 : g];
            end
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[g] <= cell_in[g];
      end

      always_ff @(posedge clock) begin
         if (reset || cmd.accept) begin
            vld_ff[g] <= 1'b0;
         end else if (rd_vld_ff) begin
            if (g == 0) begin
               vld_ff[g] <= 1'b1;
            end else begin
               vld_ff[g] <= vld_ff[g] | vld_ff[(g > 0) ? g - 1 : g];
            end
         end
      end
   end

   // restoring divider, one quotient bit per step
   assign abs_sum   = sum_ff[SW-1] ? (~sum_ff + SW'(1)) : sum_ff;
   assign div_en    = cmd.calc_step && (div_cnt_ff != DCW'(NW));
   assign rem_shift = {rem_ff, quo_ff[NW-1]};
   assign rem_ge    = (rem_shift >= {1'b0, w_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff   <= '0;
         shift_cnt_ff <= '0;
      end else if (cmd.calc_start) begin
         div_cnt_ff   <= '0;
         shift_cnt_ff <= '0;
      end else begin
         if (div_en) begin
            div_cnt_ff <= div_cnt_ff + DCW'(1);
         end
         if (shift_en) begin
            shift_cnt_ff <= shift_cnt_ff + WW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_start) begin
         rem_ff <= '0;
         quo_ff <= abs_sum[NW-1:0];
         neg_ff <= sum_ff[SW-1];
      end else if (div_en) begin
         rem_ff <= rem_ge ? WW'(rem_shift - {1'b0, w_ff}) : rem_shift[WW-1:0];
         quo_ff <= {quo_ff[NW-2:0], rem_ge};
      end
   end

   assign mean_in   = neg_ff ? SAMPLE_W'(~quo_ff[SAMPLE_W-1:0] + SAMPLE_W'(1))
                             : quo_ff[SAMPLE_W-1:0];
   assign blend_sum = {mean_in[SAMPLE_W-1], mean_in} + {cell_ff[0][SAMPLE_W-1], cell_ff[0]};
   assign blend_adj = blend_sum + {{SAMPLE_W{1'b0}}, blend_sum[SAMPLE_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         mean_ff   <= mean_in;
         median_ff <= cell_ff[0];
         blend_ff  <= blend_adj[SAMPLE_W:1];
      end
   end

   assign status.hit        = hit_ff;
   assign status.fetch_last = (rd_cnt_ff == w_ff - WW'(1));
   assign status.calc_done  = (div_cnt_ff == DCW'(NW)) && (shift_cnt_ff == half_w);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_value   = mean_ff;
   assign rsp_median_value = median_ff;
   assign rsp_blend_value  = blend_ff;

endmodule

`default_nettype wire

// File: dv/tb_sliding_mean_median_filter_core.sv
// ----------------------------------------------------------------------------
// tb_sliding_mean_median_filter_core
// Self-checking bench for the sliding mean/median/blend filter. A clocked
// driver feeds sample words from a backlog with random gaps, and a clocked
// monitor stalls the result channel at random. Each accepted sample runs
// through a local model of the window, and every result word is checked
// field by field against the oldest predicted statistics. The window size is
// rewritten between phases, once the block has drained. This covers the
// extremes, zero and oversize values, and size changes in mid-sequence.
// ----------------------------------------------------------------------------
module tb_sliding_mean_median_filter_core import smm_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } sample_word_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] mean;
      logic signed [SAMPLE_W-1:0] median;
      logic signed [SAMPLE_W-1:0] blend;
   } filter_stats_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   smm_req_if req_if();
   smm_rsp_if rsp_if();

   sliding_mean_median_filter_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sample_word_type  sample_backlog[$];
   filter_stats_type expected_stats[$];
   sample_word_type  cur_word;
   int               req_gap;
   int               rsp_gap;
   int               err_count;
   bit               steady;

   // window model
   logic signed [SAMPLE_W-1:0] win_mem [DEF_MAX_WINDOW];
   int                         fill_cnt;
   int                         wr_pos;
   logic [CSR_W-1:0]           cfg_window;

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic flag_error(string msg);
      $display("MISMATCH: %s", msg);
      err_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 60);
   endfunction

   function automatic int window_len(logic [CSR_W-1:0] cfg);
      if (cfg == 0)
         return 1;
      else if (cfg > DEF_MAX_WINDOW)
         return DEF_MAX_WINDOW;
      else
         return int'(cfg);
   endfunction

   function automatic void predict_filter(sample_word_type w);
      int win[DEF_MAX_WINDOW];
      int len;
      int sum;
      int mean;
      int med;
      int key;
      int j;
      filter_stats_type st;
      len = window_len(cfg_window);
      win_mem[wr_pos] = w.sample;
      wr_pos = (wr_pos + 1) % DEF_MAX_WINDOW;
      if (fill_cnt < DEF_MAX_WINDOW)
         fill_cnt++;
      if (fill_cnt >= len) begin
         sum = 0;
         for (int i = 0; i < len; i++) begin
            win[i] = win_mem[(wr_pos + DEF_MAX_WINDOW - len + i) % DEF_MAX_WINDOW];
            sum += win[i];
         end
         mean = sum / len;
         for (int i = 1; i < len; i++) begin
            key = win[i];
            j = i;
            while (j > 0 && win[j-1] > key) begin
               win[j] = win[j-1];
               j--;
            end
            win[j] = key;
         end
         med = win[len / 2];
         st.mean   = SAMPLE_W'(mean);
         st.median = SAMPLE_W'(med);
         st.blend  = SAMPLE_W'((mean + med) / 2);
         expected_stats.push_back(st);
      end
      if (w.last_sample) begin
         fill_cnt = 0;
         wr_pos = 0;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            predict_filter(cur_word);
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (sample_backlog.size() > 0) begin
               cur_word = sample_backlog.pop_front();
               req_if.valid       <= 1'b1;
               req_if.sample      <= cur_word.sample;
               req_if.last_sample <= cur_word.last_sample;
               req_gap = pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      filter_stats_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_stats.size() == 0) begin
               flag_error($sformatf("unexpected result word mean=%0d median=%0d blend=%0d",
                  rsp_if.mean_value, rsp_if.median_value, rsp_if.blend_value));
            end else begin
               want = expected_stats.pop_front();
               if (rsp_if.mean_value !== want.mean)
                  flag_error($sformatf("mean_value got %0d expected %0d",
                     rsp_if.mean_value, want.mean));
               if (rsp_if.median_value !== want.median)
                  flag_error($sformatf("median_value got %0d expected %0d",
                     rsp_if.median_value, want.median));
               if (rsp_if.blend_value !== want.blend)
                  flag_error($sformatf("blend_value got %0d expected %0d",
                     rsp_if.blend_value, want.blend));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               rsp_gap = pick_gap();
         end
      end
   end

   task automatic push_word(int s, bit last);
      sample_word_type w;
      w.sample      = SAMPLE_W'(s);
      w.last_sample = last;
      sample_backlog.push_back(w);
   endtask

   function automatic int pick_sample();
      logic [31:0] r32;
      int r;
      r = $urandom_range(0, 9);
      r32 = $urandom();
      if (r == 0)
         return 32767;
      else if (r == 1)
         return -32768;
      else if (r < 4)
         return $urandom_range(0, 15) - 8;
      else
         return $signed(r32[SAMPLE_W-1:0]);
   endfunction

   // hold until backlog, bus and expected results are all empty
   task automatic wait_drained();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_if.valid || expected_stats.size() != 0);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_window(logic [CSR_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cfg_window = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      steady = ($urandom_range(0, 3) == 0);
   endtask

   task automatic fill_random_phase(int n);
      int count;
      int kind;
      int len;
      int span;
      count = 0;
      span = window_len(cfg_window);
      while (count < n) begin
         kind = $urandom_range(0, 9);
         if (kind < 7)
            len = span + $urandom_range(0, 12);
         else
            len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++)
            push_word(pick_sample(), (kind < 9) && (i == len - 1));
         count += len;
      end
   endtask

   initial begin
      logic [CSR_W-1:0] cfg_list[6];
      cfg_list = '{5'd16, 5'd17, 5'd31, 5'd0, 5'd1, 5'd2};
      err_count          = 0;
      req_gap            = 0;
      rsp_gap            = 0;
      steady             = 1'b0;
      fill_cnt           = 0;
      wr_pos             = 0;
      cfg_window         = CSR_RESET;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.sample      = '0;
      req_if.last_sample = 1'b0;
      rsp_if.ready       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset window of three: extremes, negative truncation, short sequence
      push_word(32767, 0);
      push_word(-32768, 0);
      push_word(32767, 0);
      push_word(-32768, 0);
      push_word(-32768, 1);
      push_word(-1, 0);
      push_word(-2, 0);
      push_word(0, 1);
      push_word(5, 0);
      push_word(6, 1);

      write_window(5'd1);
      push_word(-7, 0);
      push_word(7, 1);
      push_word(-32768, 1);

      write_window(5'd0);
      push_word(-3, 0);
      push_word(4, 0);

      // grow the window while the sequence continues
      write_window(5'd2);
      push_word(-5, 0);
      push_word(5, 0);
      push_word(-1, 0);
      push_word(-2, 1);

      write_window(5'd4);
      push_word(1, 0);
      push_word(2, 0);
      push_word(3, 0);
      push_word(4, 1);

      for (int p = 0; p < 14; p++) begin
         if (p < 6)
            write_window(cfg_list[p]);
         else
            write_window(CSR_W'($urandom_range(0, 31)));
         fill_random_phase(40);
      end

      wait_drained();
      if (err_count == 0 && expected_stats.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
hdl/smm_pkg.sv
hdl/smm_req_if.sv
hdl/smm_rsp_if.sv
hdl/smm_ctl.sv
hdl/smm_dp.sv
hdl/sliding_mean_median_filter_core.sv
dv/tb_sliding_mean_median_filter_core.sv
